[hdl/rrd_pkg.sv]
// Shared constants, types and codes of the round-robin drain block.
package rrd_pkg;

  localparam int NUM_STREAMS   = 8;
  localparam int QUEUE_DEPTH   = 256;
  localparam int ID_WIDTH      = 32;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int STR_W   = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int PTR_W   = $clog2(NUM_STREAMS + 1);
  localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_STREAMS * QUEUE_DEPTH);
  localparam int ENTRY_W = ID_WIDTH + PAYLOAD_WIDTH;
  localparam int MASK_W  = 8;
  localparam int CAPR_W  = 9;
  localparam int CNTR_W  = 4;
  localparam int CFG_DW  = 9;
  localparam int CFG_IW  = 2;

  localparam logic [CFG_IW-1:0] CFG_STREAM_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ACTIVE_MASK  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CAPACITY     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Effective configuration, already clamped to legal ranges
  typedef struct packed {
    logic [PTR_W-1:0]  count;
    logic [MASK_W-1:0] active;
    logic [FILL_W-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [STR_W-1:0] stream;
    logic [PTR_W-1:0] ptr_nxt;
  } scan_t;

endpackage

[hdl/rrd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rrd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/rrd_cfg_regs.sv]
// Configuration registers and their clamped working values.
module rrd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [rrd_pkg::CFG_IW-1:0] wr_index,
  input  logic [rrd_pkg::CFG_DW-1:0] wr_data,
  output rrd_pkg::cfg_t              cfg
);

  logic [rrd_pkg::CNTR_W-1:0] stream_count_r;
  logic [rrd_pkg::MASK_W-1:0] active_mask_r;
  logic [rrd_pkg::CAPR_W-1:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_count_r <= rrd_pkg::CNTR_W'(1);
      active_mask_r  <= '0;
      capacity_r     <= rrd_pkg::CAPR_W'(256);
    end else if (wr_en) begin
      unique case (wr_index)
        rrd_pkg::CFG_STREAM_COUNT: stream_count_r <= wr_data[rrd_pkg::CNTR_W-1:0];
        rrd_pkg::CFG_ACTIVE_MASK:  active_mask_r  <= wr_data[rrd_pkg::MASK_W-1:0];
        rrd_pkg::CFG_CAPACITY:     capacity_r     <= wr_data[rrd_pkg::CAPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.count  = (32'(stream_count_r) > rrd_pkg::NUM_STREAMS)
               ? rrd_pkg::PTR_W'(rrd_pkg::NUM_STREAMS) : rrd_pkg::PTR_W'(stream_count_r);
    cfg.active = active_mask_r;
    if (32'(capacity_r) < 2) begin
      cfg.cap = rrd_pkg::FILL_W'(2);
    end else if (32'(capacity_r) > rrd_pkg::QUEUE_DEPTH) begin
      cfg.cap = rrd_pkg::FILL_W'(rrd_pkg::QUEUE_DEPTH);
    end else begin
      cfg.cap = rrd_pkg::FILL_W'(capacity_r);
    end
  end

endmodule

[hdl/rrd_scan.sv]
// Round-robin priority scan over the per-stream non-empty flags.
module rrd_scan (
  input  rrd_pkg::cfg_t                     cfg,
  input  logic [rrd_pkg::PTR_W-1:0]         ptr,
  input  logic [rrd_pkg::NUM_STREAMS-1:0]   nonempty,
  output rrd_pkg::scan_t                    scan
);

  logic [rrd_pkg::PTR_W-1:0] first;
  logic                      act;

  always_comb begin
    // pointer restarts at zero once it reaches the stream count; no wrap
    first = (ptr >= cfg.count) ? '0 : ptr;
    scan.found  = 1'b0;
    scan.stream = '0;
    act         = 1'b0;
    for (int i = 0; i < rrd_pkg::NUM_STREAMS; i++) begin
      act = (i < rrd_pkg::MASK_W) ? cfg.active[i % rrd_pkg::MASK_W] : 1'b0;
      if (!scan.found && rrd_pkg::PTR_W'(i) >= first && rrd_pkg::PTR_W'(i) < cfg.count
          && act && nonempty[i]) begin
        scan.found  = 1'b1;
        scan.stream = rrd_pkg::STR_W'(i);
      end
    end
    scan.ptr_nxt = scan.found ? rrd_pkg::PTR_W'(scan.stream) + rrd_pkg::PTR_W'(1) : cfg.count;
  end

endmodule

[hdl/round_robin_drain_with_overload_drop_core.sv]
// Top level: per-stream event FIFOs in one RAM, round-robin drain with overload drop.
//
// Usage:
//   Input items are issued with start and taken on a rising edge where busy is
//   low. in_req_type 0 pushes (in_stream_sel, in_event_id, in_event_payload);
//   1 pulls the next event of the first active, non-empty stream at or after
//   the round-robin pointer. An overloaded stream (fill above 80% of capacity)
//   answers a pull with a drop notice and loses capacity/2 oldest events.
//   Every item yields exactly one result, shown for one cycle with out_strobe,
//   after the item has passed the execute state into the result state. The
//   receiver cannot stall the block. The execute state does the scan and the
//   store access and starts the registered read of the event RAM. A new item is
//   taken in the same cycle the previous result is shown. Configuration is a
//   valid/ready write port (cfg_ready is always high), written only while no item
//   is in flight: a rule for the user, which the block itself does not enforce.
//   Reset (synchronous, rst_n low) empties all streams, zeroes the pointer and
//   loads stream_count 1, active_mask 0, queue_capacity 256. The event RAM is
//   not cleared; only counted entries are ever read.
module round_robin_drain_with_overload_drop_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [2:0]                        in_stream_sel,
  input  logic [31:0]                       in_event_id,
  input  logic [31:0]                       in_event_payload,
  output logic                              out_strobe,
  output logic                              out_valid,
  output logic [2:0]                        out_stream,
  output logic                              out_is_dropped,
  output logic [31:0]                       out_event_id,
  output logic [31:0]                       out_payload,
  output logic [7:0]                        out_drop_count,
  output logic                              out_push_rejected,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrd_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [rrd_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int NS = rrd_pkg::NUM_STREAMS;

  rrd_pkg::state_t state_r, state_nxt;
  rrd_pkg::cfg_t   cfg;
  rrd_pkg::scan_t  scan;

  logic accept;

  // captured request
  logic        req_type_r;
  logic [2:0]  sel_r;
  logic [31:0] id_r;
  logic [31:0] payload_r;

  logic [rrd_pkg::QIDX_W-1:0] head_r [NS];
  logic [rrd_pkg::QIDX_W-1:0] tail_r [NS];
  logic [rrd_pkg::FILL_W-1:0] fill_r [NS];
  logic [rrd_pkg::PTR_W-1:0]  ptr_r;
  logic [NS-1:0]              nonempty;

  // response registers
  logic       res_valid_r;
  logic [2:0] res_stream_r;
  logic       res_drop_r;
  logic [7:0] res_count_r;
  logic       res_rej_r;

  // datapath
  logic [rrd_pkg::STR_W-1:0]    sel_idx;
  logic                         sel_ok;
  logic                         push_ok;
  logic [rrd_pkg::FILL_W-1:0]   fill_p;
  logic [rrd_pkg::FILL_W+2:0]   fill_x5;
  logic [rrd_pkg::FILL_W+2:0]   cap_x4;
  logic                         overload;
  logic [rrd_pkg::FILL_W-1:0]   half;
  logic [rrd_pkg::FILL_W-1:0]   n_take;
  logic [rrd_pkg::QIDX_W:0]     head_sum;
  logic [rrd_pkg::QIDX_W-1:0]   head_adv;
  logic [rrd_pkg::QIDX_W:0]     tail_sum;
  logic [rrd_pkg::QIDX_W-1:0]   tail_adv;
  logic [7:0]                   count_sat;

  logic                          ram_we;
  logic                          ram_re;
  logic [rrd_pkg::ADDR_W-1:0]    ram_waddr;
  logic [rrd_pkg::ADDR_W-1:0]    ram_raddr;
  logic [rrd_pkg::ENTRY_W-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;

  rrd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      nonempty[i] = (fill_r[i] != '0);
    end
  end

  rrd_scan u_scan (
    .cfg      (cfg),
    .ptr      (ptr_r),
    .nonempty (nonempty),
    .scan     (scan)
  );

  // ---- control ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    busy       = (state_r == rrd_pkg::ST_EXEC);
    accept     = start && !busy;
    out_strobe = (state_r == rrd_pkg::ST_RESP);
    unique case (state_r)
      rrd_pkg::ST_IDLE: state_nxt = accept ? rrd_pkg::ST_EXEC : rrd_pkg::ST_IDLE;
      rrd_pkg::ST_EXEC: state_nxt = rrd_pkg::ST_RESP;
      rrd_pkg::ST_RESP: state_nxt = accept ? rrd_pkg::ST_EXEC : rrd_pkg::ST_IDLE;
      default:          state_nxt = rrd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req_type;
      sel_r      <= in_stream_sel;
      id_r       <= in_event_id;
      payload_r  <= in_event_payload;
    end
  end

  // ---- execute-cycle datapath ----
  always_comb begin
    sel_idx  = rrd_pkg::STR_W'(sel_r);
    sel_ok   = 32'(sel_r) < 32'(cfg.count);
    push_ok  = sel_ok && (fill_r[sel_idx] < cfg.cap);

    fill_p   = fill_r[scan.stream];
    fill_x5  = {1'b0, fill_p, 2'b00} + (rrd_pkg::FILL_W+3)'(fill_p);
    cap_x4   = {1'b0, cfg.cap, 2'b00};
    overload = fill_x5 > cap_x4;
    half     = cfg.cap >> 1;
    n_take   = overload ? ((half > fill_p) ? fill_p : half) : rrd_pkg::FILL_W'(1);

    // index advance modulo the queue depth (step is below the depth)
    head_sum = {1'b0, head_r[scan.stream]} + (rrd_pkg::QIDX_W+1)'(n_take);
    head_adv = (32'(head_sum) >= rrd_pkg::QUEUE_DEPTH)
             ? rrd_pkg::QIDX_W'(32'(head_sum) - rrd_pkg::QUEUE_DEPTH)
             : rrd_pkg::QIDX_W'(head_sum);
    tail_sum = {1'b0, tail_r[sel_idx]} + (rrd_pkg::QIDX_W+1)'(1);
    tail_adv = (32'(tail_sum) >= rrd_pkg::QUEUE_DEPTH)
             ? rrd_pkg::QIDX_W'(32'(tail_sum) - rrd_pkg::QUEUE_DEPTH)
             : rrd_pkg::QIDX_W'(tail_sum);
    count_sat = (32'(n_take) > 255) ? 8'd255 : 8'(n_take);

    ram_we    = busy && !req_type_r && push_ok;
    ram_re    = busy && req_type_r && scan.found;
    ram_waddr = rrd_pkg::ADDR_W'(32'(sel_idx) * rrd_pkg::QUEUE_DEPTH + 32'(tail_r[sel_idx]));
    ram_raddr = rrd_pkg::ADDR_W'(32'(scan.stream) * rrd_pkg::QUEUE_DEPTH
                                 + 32'(head_r[scan.stream]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
      ptr_r <= '0;
    end else if (busy) begin
      if (!req_type_r) begin
        if (push_ok) begin
          tail_r[sel_idx] <= tail_adv;
          fill_r[sel_idx] <= fill_r[sel_idx] + rrd_pkg::FILL_W'(1);
        end
      end else begin
        ptr_r <= scan.ptr_nxt;
        if (scan.found) begin
          head_r[scan.stream] <= head_adv;
          fill_r[scan.stream] <= fill_p - n_take;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_drop_r  <= 1'b0;
      res_rej_r   <= 1'b0;
    end else if (busy) begin
      res_valid_r <= req_type_r && scan.found;
      res_drop_r  <= req_type_r && scan.found && overload;
      res_rej_r   <= !req_type_r && !push_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      res_stream_r <= (req_type_r && scan.found) ? 3'(scan.stream) : 3'd0;
      res_count_r  <= (req_type_r && scan.found && overload) ? count_sat : 8'd0;
    end
  end

  rrd_ram #(
    .WIDTH (rrd_pkg::ENTRY_W),
    .DEPTH (NS * rrd_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({id_r[rrd_pkg::ID_WIDTH-1:0], payload_r[rrd_pkg::PAYLOAD_WIDTH-1:0]}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- result ports ----
  always_comb begin
    out_valid         = res_valid_r;
    out_stream        = res_stream_r;
    out_is_dropped    = res_drop_r;
    out_drop_count    = res_count_r;
    out_push_rejected = res_rej_r;
    out_event_id      = res_valid_r
                      ? 32'(ram_rdata[rrd_pkg::ENTRY_W-1:rrd_pkg::PAYLOAD_WIDTH]) : 32'd0;
    out_payload       = (res_valid_r && !res_drop_r)
                      ? 32'(ram_rdata[rrd_pkg::PAYLOAD_WIDTH-1:0]) : 32'd0;
  end

`ifndef SYNTHESIS
  a_exec_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rrd_pkg::ST_EXEC |=> out_strobe)
    else $error("execute cycle not followed by a result");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == rrd_pkg::ST_EXEC)
    else $error("accepted item did not enter execute");

  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("event RAM read and written in one cycle");

  a_reject_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_push_rejected) |-> (!out_valid && !out_is_dropped))
    else $error("rejected push reported with an event");

  a_drop_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_dropped) |-> (out_valid && out_drop_count != 8'd0))
    else $error("drop notice without a drop count");
`endif

endmodule

[bench/tb_round_robin_drain_with_overload_drop_core.sv]
`timescale 1ns / 100ps
// Testbench for the round-robin drain core: directed table, then random phases against a predictor.
module tb_round_robin_drain_with_overload_drop_core;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;
  localparam logic [rrd_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES  = 4;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 66;
  localparam int NO_IDLE_PHASE = 2;
  localparam int WIDE_PHASE    = 5;
  localparam int HOLD_PHASE    = 4;

  typedef struct packed {
    logic        valid;
    logic [2:0]  stream;
    logic        dropped;
    logic [31:0] id;
    logic [31:0] payload;
    logic [7:0]  dcount;
    logic        rejected;
  } drain_result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] payload;
  } event_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       rq;
    logic [2:0]                 sel;
    logic [31:0]                id;
    logic [31:0]                pl;
    logic [rrd_pkg::CFG_IW-1:0] reg_idx;
    logic [rrd_pkg::CFG_DW-1:0] reg_val;
    bit                         pinned;
    drain_result_t              want;
  } plan_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_req_type;
  logic [2:0]                 in_stream_sel;
  logic [31:0]                in_event_id;
  logic [31:0]                in_event_payload;
  logic                       out_strobe;
  logic                       out_valid;
  logic [2:0]                 out_stream;
  logic                       out_is_dropped;
  logic [31:0]                out_event_id;
  logic [31:0]                out_payload;
  logic [7:0]                 out_drop_count;
  logic                       out_push_rejected;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [rrd_pkg::CFG_IW-1:0] cfg_index;
  logic [rrd_pkg::CFG_DW-1:0] cfg_data;

  // predictor state
  event_t        fifo_mem [rrd_pkg::NUM_STREAMS][rrd_pkg::QUEUE_DEPTH];
  int            fifo_head [rrd_pkg::NUM_STREAMS];
  int            fifo_tail [rrd_pkg::NUM_STREAMS];
  int            fifo_fill [rrd_pkg::NUM_STREAMS];
  int            rr_ptr;
  int            reg_streams;
  logic [7:0]    reg_mask;
  int            reg_cap;

  drain_result_t pending_q[$];
  drain_result_t pinned_result;
  bit            pin_exp;
  int            error_count;
  plan_row_t     plan[$];

  round_robin_drain_with_overload_drop_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_stream_sel     (in_stream_sel),
    .in_event_id       (in_event_id),
    .in_event_payload  (in_event_payload),
    .out_strobe        (out_strobe),
    .out_valid         (out_valid),
    .out_stream        (out_stream),
    .out_is_dropped    (out_is_dropped),
    .out_event_id      (out_event_id),
    .out_payload       (out_payload),
    .out_drop_count    (out_drop_count),
    .out_push_rejected (out_push_rejected),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic drain_result_t mk_result(input logic v, input logic [2:0] s,
                                              input logic d, input logic [31:0] id,
                                              input logic [31:0] pl, input logic [7:0] n,
                                              input logic rej);
    drain_result_t r;
    r = '{valid: v, stream: s, dropped: d, id: id, payload: pl, dcount: n, rejected: rej};
    return r;
  endfunction

  // Serve one item against the predictor state and return its result.
  function automatic drain_result_t serve_item(input logic rq, input logic [2:0] sel,
                                               input logic [31:0] id, input logic [31:0] pl);
    int streams;
    int cap;
    int s;
    int n;
    drain_result_t r;
    streams = (reg_streams > rrd_pkg::NUM_STREAMS) ? rrd_pkg::NUM_STREAMS : reg_streams;
    cap = (reg_cap < 2) ? 2 : ((reg_cap > rrd_pkg::QUEUE_DEPTH) ? rrd_pkg::QUEUE_DEPTH : reg_cap);
    r = '0;
    if (rq == REQ_PUSH) begin
      if (int'(sel) >= streams || fifo_fill[sel] >= cap) begin
        r.rejected = 1'b1;
      end else begin
        fifo_mem[sel][fifo_tail[sel]] = '{id: id, payload: pl};
        fifo_tail[sel] = (fifo_tail[sel] + 1) % rrd_pkg::QUEUE_DEPTH;
        fifo_fill[sel]++;
      end
      return r;
    end
    if (rr_ptr >= streams) rr_ptr = 0;
    // forward scan, no wrap: an unserved pull leaves the pointer at the count
    while (rr_ptr < streams) begin
      s = rr_ptr;
      rr_ptr++;
      if (!reg_mask[s] || fifo_fill[s] == 0) continue;
      r.valid  = 1'b1;
      r.stream = s[2:0];
      r.id     = fifo_mem[s][fifo_head[s]].id;
      if (5 * fifo_fill[s] > 4 * cap) begin
        n = cap / 2;
        if (n > fifo_fill[s]) n = fifo_fill[s];
        fifo_head[s] = (fifo_head[s] + n) % rrd_pkg::QUEUE_DEPTH;
        fifo_fill[s] -= n;
        r.dropped = 1'b1;
        r.dcount  = (n > 255) ? 8'd255 : n[7:0];
      end else begin
        r.payload = fifo_mem[s][fifo_head[s]].payload;
        fifo_head[s] = (fifo_head[s] + 1) % rrd_pkg::QUEUE_DEPTH;
        fifo_fill[s]--;
      end
      return r;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    drain_result_t got;
    drain_result_t want;
    drain_result_t pred;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rrd_pkg::CFG_STREAM_COUNT: reg_streams = int'(cfg_data[3:0]);
          rrd_pkg::CFG_ACTIVE_MASK:  reg_mask = cfg_data[7:0];
          rrd_pkg::CFG_CAPACITY:     reg_cap = int'(cfg_data);
          default: ;
        endcase
      end
      if (out_strobe) begin
        got = {out_valid, out_stream, out_is_dropped, out_event_id, out_payload,
               out_drop_count, out_push_rejected};
        if (pending_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          error_count++;
        end else begin
          want = pending_q.pop_front();
          check_field("out_valid", want.valid, got.valid);
          check_field("out_stream", want.stream, got.stream);
          check_field("out_is_dropped", want.dropped, got.dropped);
          check_field("out_event_id", want.id, got.id);
          check_field("out_payload", want.payload, got.payload);
          check_field("out_drop_count", want.dcount, got.dcount);
          check_field("out_push_rejected", want.rejected, got.rejected);
        end
      end
      if (start && !busy) begin
        pred = serve_item(in_req_type, in_stream_sel, in_event_id, in_event_payload);
        pending_q.push_back(pin_exp ? pinned_result : pred);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue(input logic rq, input logic [2:0] sel, input logic [31:0] id,
                       input logic [31:0] pl);
    start            <= 1'b1;
    in_req_type      <= rq;
    in_stream_sel    <= sel;
    in_event_id      <= id;
    in_event_payload <= pl;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [rrd_pkg::CFG_IW-1:0] idx,
                           input logic [rrd_pkg::CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic plan_row_t item_row(input logic rq, input logic [2:0] sel,
                                         input logic [31:0] id, input logic [31:0] pl);
    plan_row_t row;
    row.kind    = ROW_ITEM;
    row.rq      = rq;
    row.sel     = sel;
    row.id      = id;
    row.pl      = pl;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.pinned  = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic plan_row_t pinned_row(input logic rq, input logic [2:0] sel,
                                           input logic [31:0] id, input logic [31:0] pl,
                                           input drain_result_t want);
    plan_row_t row;
    row        = item_row(rq, sel, id, pl);
    row.pinned = 1'b1;
    row.want   = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [rrd_pkg::CFG_IW-1:0] idx,
                                        input logic [rrd_pkg::CFG_DW-1:0] val);
    plan_row_t row;
    row         = item_row(REQ_PUSH, 3'd0, 32'd0, 32'd0);
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  initial begin
    drain_result_t none;
    drain_result_t refused;
    int phase;
    int k;
    int cnt;
    int eff;
    int cap;
    int push_pct;
    logic [7:0] msk;
    logic [2:0] sel;

    none    = '0;
    refused = mk_result(1'b0, 3'd0, 1'b0, 32'd0, 32'd0, 8'd0, 1'b1);
    for (k = 0; k < rrd_pkg::NUM_STREAMS; k++) begin
      fifo_head[k] = 0;
      fifo_tail[k] = 0;
      fifo_fill[k] = 0;
    end
    rr_ptr      = 0;
    reg_streams = 1;
    reg_mask    = 8'h00;
    reg_cap     = 256;
    error_count = 0;
    pin_exp     = 1'b0;
    pinned_result = '0;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_req_type      = REQ_PUSH;
    in_stream_sel    = '0;
    in_event_id      = '0;
    in_event_payload = '0;
    cfg_valid        = 1'b0;
    cfg_index        = rrd_pkg::CFG_STREAM_COUNT;
    cfg_data         = '0;

    // reset settings: one stream, nothing active
    plan.push_back(pinned_row(REQ_PULL, 3'd0, 32'd0, 32'd0, none));
    plan.push_back(pinned_row(REQ_PUSH, 3'd0, 32'hFFFF_FFFF, 32'h0, none));
    plan.push_back(pinned_row(REQ_PUSH, 3'd7, 32'h0, 32'hFFFF_FFFF, refused));
    plan.push_back(pinned_row(REQ_PULL, 3'd0, 32'd0, 32'd0, none));
    // count above range, all active, capacity below range
    plan.push_back(cfg_row(rrd_pkg::CFG_ACTIVE_MASK, 9'h0FF));
    plan.push_back(cfg_row(rrd_pkg::CFG_STREAM_COUNT, 9'h00F));
    plan.push_back(cfg_row(rrd_pkg::CFG_CAPACITY, 9'h000));
    plan.push_back(cfg_row(CFG_UNUSED, 9'h1FF));
    // pointer still sits at 1, and streams 1..7 are empty
    plan.push_back(pinned_row(REQ_PULL, 3'd0, 32'd0, 32'd0, none));
    plan.push_back(item_row(REQ_PUSH, 3'd7, 32'h0, 32'hFFFF_FFFF));
    plan.push_back(item_row(REQ_PUSH, 3'd7, 32'h1, 32'h1));
    plan.push_back(pinned_row(REQ_PUSH, 3'd7, 32'h2, 32'h2, refused));
    plan.push_back(item_row(REQ_PULL, 3'd0, 32'd0, 32'd0));
    plan.push_back(item_row(REQ_PULL, 3'd0, 32'd0, 32'd0));
    // zero streams: nothing served, every push refused
    plan.push_back(cfg_row(rrd_pkg::CFG_CAPACITY, 9'h1FF));
    plan.push_back(cfg_row(rrd_pkg::CFG_STREAM_COUNT, 9'h000));
    plan.push_back(pinned_row(REQ_PUSH, 3'd0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, refused));
    plan.push_back(pinned_row(REQ_PULL, 3'd0, 32'd0, 32'd0, none));
    // upper data bits must be ignored; only stream 7 active, capacity 5
    plan.push_back(cfg_row(rrd_pkg::CFG_STREAM_COUNT, 9'h1F8));
    plan.push_back(cfg_row(rrd_pkg::CFG_ACTIVE_MASK, 9'h180));
    plan.push_back(cfg_row(rrd_pkg::CFG_CAPACITY, 9'h005));
    for (k = 0; k < 5; k++) begin
      plan.push_back(item_row(REQ_PUSH, 3'd7, 32'hA0 + k, $urandom));
    end
    plan.push_back(pinned_row(REQ_PUSH, 3'd7, 32'hA5, 32'h0, refused));
    plan.push_back(item_row(REQ_PUSH, 3'd3, 32'h33, 32'h3333));
    // capacity lowered below the fill of stream 7
    plan.push_back(cfg_row(rrd_pkg::CFG_CAPACITY, 9'h002));
    plan.push_back(pinned_row(REQ_PUSH, 3'd7, 32'hA6, 32'h0, refused));
    plan.push_back(item_row(REQ_PULL, 3'd0, 32'd0, 32'd0));
    plan.push_back(item_row(REQ_PULL, 3'd0, 32'd0, 32'd0));
    plan.push_back(cfg_row(rrd_pkg::CFG_ACTIVE_MASK, 9'h088));
    plan.push_back(item_row(REQ_PULL, 3'd0, 32'd0, 32'd0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        pin_exp       = plan[i].pinned;
        pinned_result = plan[i].want;
        issue(plan[i].rq, plan[i].sel, plan[i].id, plan[i].pl);
      end
    end
    pin_exp = 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == NO_IDLE_PHASE) begin
        cnt = 15; msk = 8'hFF; cap = 0; push_pct = 65;
      end else if (phase == WIDE_PHASE) begin
        cnt = 1; msk = 8'h01; cap = 511; push_pct = 85;
      end else begin
        cnt = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(15, 0);
        msk = ($urandom_range(99) < 50) ? 8'hFF : 8'($urandom);
        cap = ($urandom_range(99) < 80) ? $urandom_range(12, 2) : $urandom_range(511, 0);
        push_pct = $urandom_range(75, 45);
      end
      eff = (cnt > rrd_pkg::NUM_STREAMS) ? rrd_pkg::NUM_STREAMS : cnt;
      wait_drained();
      write_reg(rrd_pkg::CFG_STREAM_COUNT, {5'($urandom), 4'(cnt)});
      write_reg(rrd_pkg::CFG_ACTIVE_MASK, {1'($urandom), msk});
      write_reg(rrd_pkg::CFG_CAPACITY, 9'(cap));

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == HOLD_PHASE && k == PHASE_ITEMS / 2) begin
          wait_drained();
        end else if (phase != NO_IDLE_PHASE && $urandom_range(99) < 30) begin
          start <= 1'b0;
          repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        // mostly target streams in use, sometimes any stream
        if (eff > 0 && $urandom_range(99) < 85) sel = 3'($urandom_range(eff - 1, 0));
        else sel = 3'($urandom_range(7, 0));
        issue(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_PULL, sel, $urandom, $urandom);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
